/* rtl/imu_fp_pkg.sv */
// Shared constants, event codes and queue entry type for the IMU frame parser.
package imu_fp_pkg;

  localparam int unsigned FILL_W      = 4;
  localparam int unsigned FRAME_LEN   = 11;
  localparam int unsigned SUM_LEN     = 10;
  localparam int unsigned Q_DEPTH_DEF = 2;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACC   = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic [1:0] EV_COLLECT  = 2'd0;
  localparam logic [1:0] EV_VALID    = 2'd1;
  localparam logic [1:0] EV_BAD_SUM  = 2'd2;
  localparam logic [1:0] EV_BAD_TYPE = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       is_hdr;
    logic       type_ok;
  } q_entry_t;

endpackage

/* rtl/imu_fp_front.sv */
// Front end: accepts received bytes, tags header and type matches, and queues them.
module imu_fp_front #(
  parameter int unsigned QUEUE_DEPTH = imu_fp_pkg::Q_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rx_valid,
  output logic                  rx_stall,
  input  logic [7:0]            rx_byte,
  output logic                  q_valid,
  output imu_fp_pkg::q_entry_t  q_entry,
  input  logic                  q_pop
);
  import imu_fp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  q_entry_t             tagged_in;
  logic                 push;
  logic                 pop;

  always_comb begin
    tagged_in.data    = rx_byte;
    tagged_in.is_hdr  = (rx_byte == HDR_BYTE);
    tagged_in.type_ok = (rx_byte == TYPE_ACC) || (rx_byte == TYPE_GYRO) ||
                        (rx_byte == TYPE_ANGLE);
  end

  assign rx_stall = (count == CNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_entry  = slots[rd_ptr];
  assign push     = rx_valid && !rx_stall;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= tagged_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/imu_fp_back.sv */
// Back end: frame store, checksum and resync sequencer, counters and result register.
module imu_fp_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  imu_fp_pkg::q_entry_t               q_entry,
  output logic                               q_pop,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic [1:0]                         event_res,
  output logic [7:0]                         frame_type,
  output logic [63:0]                        payload,
  output logic [imu_fp_pkg::FILL_W-1:0]      fill_level,
  output logic [31:0]                        rx_byte_total,
  output logic [31:0]                        valid_frame_total,
  output logic [31:0]                        bad_checksum_total
);
  import imu_fp_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state;
  logic [7:0]        store [FRAME_LEN];
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] sum_idx;
  logic [7:0]        sum;
  logic [1:0]        pend_ev;
  logic [7:0]        pend_type;
  logic [63:0]       pend_pay;
  logic [31:0]       byte_cnt;
  logic [31:0]       good_cnt;
  logic [31:0]       bad_cnt;
  logic [7:0]        last_type;
  logic [63:0]       pay_pack;
  logic              res_load;
  logic              frame_ok;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign res_load = (state == ST_DONE) && (!res_valid || !res_stall);
  assign frame_ok = (store[0] == HDR_BYTE) && (store[FRAME_LEN-1] == sum);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pay_pack[8*k +: 8] = store[2+k];
    end
  end

  // Frame bytes: a new byte lands at the fill position; a resync shifts
  // the whole store down one slot per cycle.
  always_ff @(posedge clk) begin
    if (q_pop && !(fill == '0 && !q_entry.is_hdr)) begin
      store[fill] <= q_entry.data;
    end else if (state == ST_SCAN && fill > FILL_W'(1)) begin
      for (int i = 0; i < FRAME_LEN - 1; i++) begin
        store[i] <= store[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      sum_idx   <= '0;
      sum       <= '0;
      pend_ev   <= EV_COLLECT;
      pend_type <= '0;
      pend_pay  <= '0;
      byte_cnt  <= '0;
      good_cnt  <= '0;
      bad_cnt   <= '0;
      last_type <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            byte_cnt <= byte_cnt + 1'b1;
            pend_pay <= '0;
            if (fill == '0 && !q_entry.is_hdr) begin
              pend_ev   <= EV_COLLECT;
              pend_type <= last_type;
              state     <= ST_DONE;
            end else begin
              fill <= fill + 1'b1;
              if (fill == FILL_W'(1) && !q_entry.type_ok) begin
                pend_ev   <= EV_BAD_TYPE;
                pend_type <= q_entry.data;
                state     <= ST_SCAN;
              end else begin
                pend_ev   <= EV_COLLECT;
                pend_type <= last_type;
                if (fill == FILL_W'(FRAME_LEN - 1)) begin
                  sum_idx <= '0;
                  sum     <= '0;
                  state   <= ST_SUM;
                end else begin
                  state <= ST_DONE;
                end
              end
            end
          end
        end
        ST_SUM: begin
          sum <= sum + store[sum_idx];
          if (sum_idx == FILL_W'(SUM_LEN - 1)) begin
            state <= ST_CHECK;
          end else begin
            sum_idx <= sum_idx + 1'b1;
          end
        end
        ST_CHECK: begin
          pend_type <= store[1];
          pend_pay  <= pay_pack;
          if (frame_ok) begin
            pend_ev   <= EV_VALID;
            good_cnt  <= good_cnt + 1'b1;
            last_type <= store[1];
            fill      <= '0;
            state     <= ST_DONE;
          end else begin
            pend_ev <= EV_BAD_SUM;
            bad_cnt <= bad_cnt + 1'b1;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // The byte in slot 1 becomes slot 0; stop once it is a header.
          if (fill <= FILL_W'(1)) begin
            fill  <= '0;
            state <= ST_DONE;
          end else begin
            fill <= fill - 1'b1;
            if (store[1] == HDR_BYTE) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      event_res          <= pend_ev;
      frame_type         <= pend_type;
      payload            <= pend_pay;
      fill_level         <= fill;
      rx_byte_total      <= byte_cnt;
      valid_frame_total  <= good_cnt;
      bad_checksum_total <= bad_cnt;
    end
  end

  a_check_moves_one_counter: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |=>
      ((good_cnt != $past(good_cnt)) != (bad_cnt != $past(bad_cnt))))
    else $error("checksum decision must move exactly one frame counter");

  a_scan_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (fill == '0) || (fill < $past(fill)))
    else $error("resync scan did not shrink the buffer");

  a_pop_counts_byte: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (byte_cnt == $past(byte_cnt) + 32'd1) && (state != ST_IDLE))
    else $error("accepted byte not counted or sequencer stayed idle");

  a_valid_frame_empties: assert property (@(posedge clk) disable iff (rst)
    (res_load && pend_ev == EV_VALID) |=> res_valid && (fill_level == '0))
    else $error("valid frame result does not report an empty buffer");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fill_level <= FILL_W'(FRAME_LEN - 1)))
    else $error("reported fill level beyond a partial frame");

endmodule

/* rtl/imu_frame_parser_resync_unit.sv */
// Top level of the IMU frame parser: byte queue front end and frame sequencer.
//
//   channel  direction  handshake            fields
//   rx       in         rx_valid/rx_stall    rx_byte
//   res      out        res_valid/res_stall  event_res, frame_type, payload,
//                                            fill_level, rx_byte_total,
//                                            valid_frame_total, bad_checksum_total
//
// Each byte passes the sequencer's idle and done states; a bad type byte also
// passes the resync scan. The eleventh byte of a frame runs the checksum loop,
// then the resync if the checksum fails: the checksum loop reads one stored
// byte per cycle and the resync shifts the frame store one slot per cycle.
// Reset clears the queue, fill count, counters and last type; the frame store
// is not cleared and only slots below the fill count are read.
// The input queue keeps accepting until full while the sequencer or the result
// register is stalled; a held result stops the sequencer taking the next byte.
module imu_frame_parser_resync_unit #(
  parameter int unsigned QUEUE_DEPTH = imu_fp_pkg::Q_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rx_valid,
  output logic                           rx_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [1:0]                     event_res,
  output logic [7:0]                     frame_type,
  output logic [63:0]                    payload,
  output logic [imu_fp_pkg::FILL_W-1:0]  fill_level,
  output logic [31:0]                    rx_byte_total,
  output logic [31:0]                    valid_frame_total,
  output logic [31:0]                    bad_checksum_total
);
  import imu_fp_pkg::*;

  logic     q_valid;
  logic     q_pop;
  q_entry_t q_entry;

  imu_fp_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_stall (rx_stall),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  imu_fp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_entry            (q_entry),
    .q_pop              (q_pop),
    .res_valid          (res_valid),
    .res_stall          (res_stall),
    .event_res          (event_res),
    .frame_type         (frame_type),
    .payload            (payload),
    .fill_level         (fill_level),
    .rx_byte_total      (rx_byte_total),
    .valid_frame_total  (valid_frame_total),
    .bad_checksum_total (bad_checksum_total)
  );

endmodule
